// File: src/bmri_pkg.sv
// Package for the block multi-color reorder index block.
// Word types, register indexes and sizing constants; no dependencies.
package bmri_pkg;

   localparam int MAX_GRID_DIM      = 1024;
   localparam int MAX_VECTOR_LENGTH = 8;
   localparam int VL_LOG            = $clog2(MAX_VECTOR_LENGTH);
   // bits needed to hold a vector length exponent from 0 to VL_LOG
   localparam int VL_LOG_W          = (VL_LOG > 0) ? $clog2(VL_LOG + 1) : 1;

   // register indexes of the configuration port
   typedef enum logic [2:0] {
      REG_GRID_X  = 3'd0,
      REG_GRID_Y  = 3'd1,
      REG_GRID_Z  = 3'd2,
      REG_BLOCK_X = 3'd3,
      REG_BLOCK_Y = 3'd4,
      REG_BLOCK_Z = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [9:0] coord_x;
      logic [9:0] coord_y;
      logic [9:0] coord_z;
   } req_word_type;

   typedef struct packed {
      logic [29:0] reordered_index;
      logic [2:0]  color_number;
      logic        fault;
   } rsp_word_type;

   // one axis in the divider: coordinate / block and grid / (2 * block)
   typedef struct packed {
      logic [10:0] rc;
      logic [10:0] qc;
      logic [10:0] rg;
      logic [10:0] qg;
   } axis_div_type;

   typedef struct packed {
      logic         fault;
      axis_div_type ax;
      axis_div_type ay;
      axis_div_type az;
   } div_stage_type;

endpackage

// File: src/block_multicolor_reorder_index_top.sv
// Block multi-color reorder index: top level, single module.
// Depends on bmri_pkg (word types, register indexes, constants).
//
//  channel | ports                               | direction
//  req     | req_valid, req_stall, req_word      | coordinate in
//  rsp     | rsp_valid, rsp_stall, rsp_word      | index, color, fault out
//  csr     | csr_we, csr_index, csr_wdata        | register writes in
//
// One word enters per cycle while req_stall is low; a result is registered
// through 17 register stages: an input register, the 11-step restoring
// divider (one quotient bit per stage) and five arithmetic stages.
// Synchronous active-high reset clears valid bits and loads register resets.
// Stalls back up stage by stage; empty stages are filled, nothing is lost.
module block_multicolor_reorder_index_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bmri_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bmri_pkg::rsp_word_type rsp_word,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [10:0]           csr_wdata
);
   import bmri_pkg::*;

   localparam int DIV_STEPS = 11;
   localparam int NS        = DIV_STEPS + 6;

   // configuration registers
   logic [10:0] gx_ff, gy_ff, gz_ff;
   logic [9:0]  bx_ff, by_ff, bz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gx_ff <= 11'd16;
         gy_ff <= 11'd16;
         gz_ff <= 11'd16;
         bx_ff <= 10'd4;
         by_ff <= 10'd4;
         bz_ff <= 10'd4;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_GRID_X:  gx_ff <= csr_wdata;
            REG_GRID_Y:  gy_ff <= csr_wdata;
            REG_GRID_Z:  gz_ff <= csr_wdata;
            REG_BLOCK_X: bx_ff <= csr_wdata[9:0];
            REG_BLOCK_Y: by_ff <= csr_wdata[9:0];
            REG_BLOCK_Z: bz_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // valid bits and per-stage enables
   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || !rsp_stall;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req_stall = !en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= req_valid;
         for (int i = 1; i < NS; i++) begin
            if (en[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // one restoring divide step: returns {remainder, shifted dividend/quotient}
   function automatic logic [21:0] div_step(logic [10:0] rem, logic [10:0] dvd,
                                            logic [10:0] d);
      logic [11:0] t;
      t = {rem, dvd[10]};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
         return {t[10:0], dvd[9:0], 1'b1};
      end else begin
         return {t[10:0], dvd[9:0], 1'b0};
      end
   endfunction

   function automatic axis_div_type axis_step(axis_div_type a, logic [9:0] b);
      axis_div_type r;
      logic [21:0]  sc;
      logic [21:0]  sg;
      sc = div_step(a.rc, a.qc, {1'b0, b});
      sg = div_step(a.rg, a.qg, {b, 1'b0});
      r.rc = sc[21:11];
      r.qc = sc[10:0];
      r.rg = sg[21:11];
      r.qg = sg[10:0];
      return r;
   endfunction

   function automatic logic axis_bad(logic [10:0] g, logic [9:0] b, logic [9:0] c);
      return (g == 11'd0) || (g > 11'(MAX_GRID_DIM)) || (b == 10'd0)
             || ({1'b0, c} >= g);
   endfunction

   // stage 0 (input) and divider stages
   div_stage_type dv_ff [DIV_STEPS+1];
   div_stage_type dv_in [DIV_STEPS+1];

   always_comb begin
      dv_in[0].fault = axis_bad(gx_ff, bx_ff, req_word.coord_x)
                    || axis_bad(gy_ff, by_ff, req_word.coord_y)
                    || axis_bad(gz_ff, bz_ff, req_word.coord_z);
      dv_in[0].ax = '{rc: 11'd0, qc: {1'b0, req_word.coord_x}, rg: 11'd0, qg: gx_ff};
      dv_in[0].ay = '{rc: 11'd0, qc: {1'b0, req_word.coord_y}, rg: 11'd0, qg: gy_ff};
      dv_in[0].az = '{rc: 11'd0, qc: {1'b0, req_word.coord_z}, rg: 11'd0, qg: gz_ff};
      for (int i = 1; i <= DIV_STEPS; i++) begin
         dv_in[i].fault = dv_ff[i-1].fault;
         dv_in[i].ax    = axis_step(dv_ff[i-1].ax, bx_ff);
         dv_in[i].ay    = axis_step(dv_ff[i-1].ay, by_ff);
         dv_in[i].az    = axis_step(dv_ff[i-1].az, bz_ff);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= DIV_STEPS; i++) begin
         if (en[i]) dv_ff[i] <= dv_in[i];
      end
   end

   // stage P1: divisibility check, first partial products
   logic        p1_fault_ff;
   logic [2:0]  p1_colour_ff;
   logic [9:0]  p1_nbz_ff, p1_rx_ff, p1_rz_ff, p1_bxq_ff, p1_bzq_ff;
   logic [19:0] p1_bpcxy_ff, p1_bxby_ff, p1_rybx_ff, p1_bynbx_ff;
   logic [21:0] p1_gxgy_ff;

   always_ff @(posedge clock) begin
      if (en[DIV_STEPS+1]) begin
         p1_fault_ff  <= dv_ff[DIV_STEPS].fault || (dv_ff[DIV_STEPS].ax.rg != 11'd0)
                      || (dv_ff[DIV_STEPS].ay.rg != 11'd0)
                      || (dv_ff[DIV_STEPS].az.rg != 11'd0);
         p1_colour_ff <= {dv_ff[DIV_STEPS].az.qc[0], dv_ff[DIV_STEPS].ay.qc[0],
                          dv_ff[DIV_STEPS].ax.qc[0]};
         p1_nbz_ff    <= dv_ff[DIV_STEPS].az.qg[9:0];
         p1_rx_ff     <= dv_ff[DIV_STEPS].ax.rc[9:0];
         p1_rz_ff     <= dv_ff[DIV_STEPS].az.rc[9:0];
         p1_bxq_ff    <= dv_ff[DIV_STEPS].ax.qc[10:1];
         p1_bzq_ff    <= dv_ff[DIV_STEPS].az.qc[10:1];
         p1_bpcxy_ff  <= dv_ff[DIV_STEPS].ax.qg[9:0] * dv_ff[DIV_STEPS].ay.qg[9:0];
         p1_bxby_ff   <= bx_ff * by_ff;
         p1_rybx_ff   <= dv_ff[DIV_STEPS].ay.rc[9:0] * bx_ff;
         p1_bynbx_ff  <= dv_ff[DIV_STEPS].ay.qc[10:1] * dv_ff[DIV_STEPS].ax.qg[9:0];
         p1_gxgy_ff   <= gx_ff * gy_ff;
      end
   end

   // stage P2: block counts, grid size, offset inside block, block number
   logic        p2_fault_ff;
   logic [2:0]  p2_colour_ff;
   logic [29:0] p2_bpc_ff, p2_n8_ff, p2_bsz_ff, p2_offs_ff, p2_blk_ff;
   logic [32:0] p2_n_in;
   logic [29:0] p2_rzb_in, p2_bzb_in;

   always_comb begin
      p2_n_in   = p1_gxgy_ff * gz_ff;
      p2_rzb_in = p1_rz_ff * p1_bxby_ff;
      p2_bzb_in = p1_bzq_ff * p1_bpcxy_ff;
   end

   always_ff @(posedge clock) begin
      if (en[DIV_STEPS+2]) begin
         p2_fault_ff  <= p1_fault_ff;
         p2_colour_ff <= p1_colour_ff;
         p2_bpc_ff    <= p1_bpcxy_ff * p1_nbz_ff;
         p2_n8_ff     <= p2_n_in[32:3];
         p2_bsz_ff    <= p1_bxby_ff * bz_ff;
         p2_offs_ff   <= p2_rzb_in + 30'(p1_rybx_ff) + 30'(p1_rx_ff);
         p2_blk_ff    <= p2_bzb_in + 30'(p1_bynbx_ff) + 30'(p1_bxq_ff);
      end
   end

   // stage P3: vector length, color base, interleave split
   logic                p3_fault_ff;
   logic [2:0]          p3_colour_ff;
   logic [29:0]         p3_terma_ff, p3_termc_ff, p3_blkhi_ff, p3_bszvl_ff;
   logic [VL_LOG_W-1:0] vl_log;
   logic [29:0]         vl_mask;

   always_comb begin
      vl_log = VL_LOG_W'(VL_LOG);
      for (int i = VL_LOG - 1; i >= 0; i--) begin
         if (p2_bpc_ff[i]) vl_log = VL_LOG_W'(i);
      end
      vl_mask = ~(30'h3FFF_FFFF << vl_log);
   end

   always_ff @(posedge clock) begin
      if (en[DIV_STEPS+3]) begin
         p3_fault_ff  <= p2_fault_ff;
         p3_colour_ff <= p2_colour_ff;
         p3_terma_ff  <= 30'(p2_colour_ff * p2_n8_ff);
         p3_termc_ff  <= (p2_offs_ff << vl_log) + (p2_blk_ff & vl_mask);
         p3_blkhi_ff  <= p2_blk_ff >> vl_log;
         p3_bszvl_ff  <= p2_bsz_ff << vl_log;
      end
   end

   // stage P4: group offset product
   logic        p4_fault_ff;
   logic [2:0]  p4_colour_ff;
   logic [29:0] p4_terma_ff, p4_termb_ff, p4_termc_ff;

   always_ff @(posedge clock) begin
      if (en[DIV_STEPS+4]) begin
         p4_fault_ff  <= p3_fault_ff;
         p4_colour_ff <= p3_colour_ff;
         p4_terma_ff  <= p3_terma_ff;
         p4_termc_ff  <= p3_termc_ff;
         p4_termb_ff  <= 30'(p3_blkhi_ff * p3_bszvl_ff);
      end
   end

   // stage P5: output register
   rsp_word_type out_ff;

   always_ff @(posedge clock) begin
      if (en[DIV_STEPS+5]) begin
         out_ff.fault           <= p4_fault_ff;
         out_ff.color_number    <= p4_fault_ff ? 3'd0 : p4_colour_ff;
         out_ff.reordered_index <= p4_fault_ff ? 30'd0
                                 : p4_terma_ff + p4_termb_ff + p4_termc_ff;
      end
   end

   assign rsp_valid = v_ff[NS-1];
   assign rsp_word  = out_ff;

`ifndef SYNTHESIS
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.fault |->
         rsp_word.reordered_index == 30'd0 && rsp_word.color_number == 3'd0)
      else $error("fault word carries nonzero fields");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v_ff[0])
      else $error("input stalled while first stage empty");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> v_ff[0])
      else $error("accepted word not in first stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

// File: bench/block_multicolor_reorder_index_top_tb.sv
// Testbench for block_multicolor_reorder_index_top: coordinate words in,
// reorder index words out, checked against an in-bench index calculator.
// Depends on bmri_pkg and the block's RTL only.
module block_multicolor_reorder_index_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bmri_pkg::*;

   // grid geometry and expected index words
   class index_board;
      int unsigned grid [3];
      int unsigned blk [3];
      rsp_word_type pending [$];
      int errors;

      function void set_reg(reg_index_type idx, logic [10:0] val);
         if (idx <= REG_GRID_Z) grid[idx] = val;
         else blk[idx - REG_BLOCK_X] = val[9:0];
      endfunction

      function bit axis_usable(int unsigned g, int unsigned b);
         if (b == 0 || g == 0 || g > MAX_GRID_DIM) return 0;
         return (g % (2 * b)) == 0;
      endfunction

      // work out the index word for one coordinate
      function void note_coord(req_word_type w);
         longint unsigned c [3];
         longint unsigned nb [3];
         longint unsigned bpc, n, bsz, vl, blkn, color, offs, idx;
         rsp_word_type r;
         c[0] = w.coord_x; c[1] = w.coord_y; c[2] = w.coord_z;
         r = '0;
         if (!axis_usable(grid[0], blk[0]) || !axis_usable(grid[1], blk[1]) ||
             !axis_usable(grid[2], blk[2]) || c[0] >= grid[0] ||
             c[1] >= grid[1] || c[2] >= grid[2]) begin
            r.fault = 1'b1;
         end else begin
            for (int a = 0; a < 3; a++) nb[a] = grid[a] / (2 * blk[a]);
            bpc = nb[0] * nb[1] * nb[2];
            n = longint'(grid[0]) * grid[1] * grid[2];
            bsz = longint'(blk[0]) * blk[1] * blk[2];
            vl = MAX_VECTOR_LENGTH;
            while (vl > 1 && (bpc % vl) != 0) vl = vl / 2;
            color = (((c[2] / blk[2]) & 1) << 2) | (((c[1] / blk[1]) & 1) << 1)
                  | ((c[0] / blk[0]) & 1);
            blkn = (c[2] / (2 * blk[2])) * nb[0] * nb[1]
                 + (c[1] / (2 * blk[1])) * nb[0] + c[0] / (2 * blk[0]);
            offs = (c[2] % blk[2]) * blk[0] * blk[1] + (c[1] % blk[1]) * blk[0]
                 + (c[0] % blk[0]);
            idx = color * (n / 8) + (blkn / vl) * bsz * vl + vl * offs + blkn % vl;
            r.reordered_index = idx[29:0];
            r.color_number = color[2:0];
         end
         pending.push_back(r);
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type exp;
         if (pending.size() == 0) begin
            $error("result word with none expected: %h", got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.reordered_index !== exp.reordered_index) begin
            $error("reordered_index exp %0d got %0d", exp.reordered_index,
                   got.reordered_index);
            errors++;
         end
         if (got.color_number !== exp.color_number) begin
            $error("color_number exp %0d got %0d", exp.color_number, got.color_number);
            errors++;
         end
         if (got.fault !== exp.fault) begin
            $error("fault exp %0b got %0b", exp.fault, got.fault);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_word_type rsp_word;
   logic csr_we = 0;
   logic [2:0] csr_index = '0;
   logic [10:0] csr_wdata = '0;

   index_board board = new();
   bit calm = 0;       // no idling near the end
   bit hold_long = 0;  // receiver long hold-off request
   bit run_done = 0;

   block_multicolor_reorder_index_top dut (.*);

   always #5 clock = ~clock;

   // receiver: check accepted words and stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_word(rsp_word);
   end

   initial begin
      int burst;
      @(posedge clock);
      forever begin
         if (hold_long) begin
            rsp_stall <= 1;
            repeat (60) @(posedge clock);
            hold_long = 0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 9);
            rsp_stall <= 1;
            repeat (burst) @(posedge clock);
         end else begin
            rsp_stall <= 0;
            @(posedge clock);
         end
      end
   end

   task automatic write_reg(reg_index_type idx, int unsigned val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val[10:0];
      board.set_reg(idx, val[10:0]);
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic set_geometry(int unsigned gx, gy, gz, bx, by, bz);
      write_reg(REG_GRID_X, gx);
      write_reg(REG_GRID_Y, gy);
      write_reg(REG_GRID_Z, gz);
      write_reg(REG_BLOCK_X, bx);
      write_reg(REG_BLOCK_Y, by);
      write_reg(REG_BLOCK_Z, bz);
   endtask

   // offer one word, keep valid high across back-to-back words
   task automatic send_coord(req_word_type w);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_coord(w);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic req_word_type pick_coord(int unsigned span);
      req_word_type w;
      // mostly inside the grid, sometimes anywhere
      if ($urandom_range(0, 7) == 0) begin
         w = req_word_type'(30'($urandom));
      end else begin
         w.coord_x = 10'($urandom_range(0, (span > 0 ? span : 1) - 1));
         w.coord_y = 10'($urandom_range(0, board.grid[1] > 0 ? board.grid[1] - 1 : 0));
         w.coord_z = 10'($urandom_range(0, board.grid[2] > 0 ? board.grid[2] - 1 : 0));
      end
      return w;
   endfunction

   task automatic random_phase(int count);
      req_word_type w;
      for (int i = 0; i < count; i++) begin
         w = pick_coord(board.grid[0] > 1024 ? 1024 : board.grid[0]);
         send_coord(w);
      end
      drain();
   endtask

   // pick a geometry; sizes stay valid most of the time
   task automatic random_geometry();
      int unsigned b [3];
      int unsigned g [3];
      for (int a = 0; a < 3; a++) begin
         b[a] = 1 << $urandom_range(0, 3);
         if ($urandom_range(0, 2) == 0) b[a] = $urandom_range(1, 12);
         g[a] = 2 * b[a] * $urandom_range(1, 4);
         if ($urandom_range(0, 9) == 0) g[a] = $urandom_range(0, 2047);
      end
      set_geometry(g[0], g[1], g[2], b[0], b[1], b[2]);
   endtask

   initial begin
      board.grid = '{16, 16, 16};
      board.blk = '{4, 4, 4};
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: corners under reset geometry, out-of-grid, bad sizes
      send_coord('{0, 0, 0});
      send_coord('{15, 15, 15});
      send_coord('{4, 0, 0});
      send_coord('{0, 4, 4});
      send_coord('{16, 0, 0});
      send_coord('{0, 16, 0});
      send_coord('{0, 0, 16});
      send_coord('{1023, 1023, 1023});
      send_coord('{10'h2AA, 10'h155, 10'h2AA});
      drain();
      set_geometry(1024, 1024, 1024, 512, 512, 512);
      send_coord('{1023, 1023, 1023});
      send_coord('{512, 0, 512});
      send_coord('{10'h155, 10'h2AA, 10'h155});
      drain();
      set_geometry(1024, 1024, 1024, 1, 1, 1);
      send_coord('{1023, 1023, 1023});
      send_coord('{1, 2, 3});
      drain();
      set_geometry(12, 2, 48, 3, 1, 8);   // odd veclen path
      send_coord('{11, 1, 47});
      send_coord('{5, 0, 20});
      drain();
      set_geometry(2047, 16, 16, 4, 4, 4); // grid too large
      send_coord('{0, 0, 0});
      drain();
      set_geometry(16, 16, 16, 0, 4, 4);   // zero block
      send_coord('{0, 0, 0});
      drain();
      set_geometry(24, 16, 16, 8, 4, 4);   // not divisible
      send_coord('{1, 1, 1});
      drain();
      set_geometry(0, 16, 16, 8, 4, 4);
      send_coord('{0, 0, 0});
      drain();

      // long receiver hold-off so the pipeline fills
      set_geometry(16, 16, 16, 4, 4, 4);
      hold_long = 1;
      random_phase(80);

      for (int p = 0; p < 10; p++) begin
         random_geometry();
         if (p == 8) calm = 1;
         random_phase(100);
      end

      if (board.errors == 0)
         $display("** block_multicolor_reorder_index_top: PASSED **");
      else
         $display("** block_multicolor_reorder_index_top: FAILED **");
      run_done = 1;
      $finish;
   end

   initial begin
      #2ms;
      if (!run_done) begin
         $display("** block_multicolor_reorder_index_top: FAILED **");
         $finish;
      end
   end
endmodule
